FILE: rtl/matrix_symmetry_check_unit_macros.svh
// assertion macros used by the rtl
`ifndef MATRIX_SYMMETRY_CHECK_UNIT_MACROS_SVH
`define MATRIX_SYMMETRY_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MSC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MSC_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define MSC_ASSERT(name, clk, rst_n, prop)
`define MSC_NEVER(name, clk, rst_n, expr)
`endif

`endif

FILE: rtl/msc_pkg.sv
package msc_pkg;

    localparam int MAX_DIM   = 64;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CNT_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = 2;
    localparam int KIND_W    = 2;

    localparam logic [IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_COL_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_TEST_KIND = 2'd2;

    localparam logic [KIND_W-1:0] KIND_VERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HORZ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIAG = 2'd2;

endpackage

FILE: rtl/msc_store.sv
module msc_store import msc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

FILE: rtl/matrix_symmetry_check_unit.sv
// matrix symmetry check
// configure row count (index 0), column count (index 1) and test kind (index 2)
// through the write port; any of these writes restarts the matrix being loaded.
// elements are taken in row-major order, one per transfer: i_start high while
// o_busy is low, one element per cycle. the last element starts the check and
// raises o_busy; the store is then walked with both read ports, one element
// pair per cycle: rows*floor(cols/2) pairs for the vertical mirror,
// floor(rows/2)*cols for the horizontal mirror and rows*(rows-1)/2 for the
// transpose test. o_valid pulses for one cycle with o_is_symmetric after the
// last pair is read and the drain state checks it; o_busy falls with it.
// when no pair needs comparing, or the test cannot hold (non-square transpose,
// unknown kind), the flag is registered with the last element and o_busy
// stays low. the receiver cannot stall the output; a new load may start in
// the cycle that o_valid is shown. reset restores rows 1, columns 1, vertical
// test and an empty load; the element store needs no clearing.
`include "matrix_symmetry_check_unit_macros.svh"

module matrix_symmetry_check_unit import msc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [DATA_W-1:0] i_element_value,
    output logic                     o_valid,
    output logic                     o_is_symmetric,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_row_count;
    logic [CFG_W-1:0]   r_col_count;
    logic [KIND_W-1:0]  r_test_kind;
    logic [CNT_W-1:0]   r_ld_row;
    logic [CNT_W-1:0]   r_ld_col;
    logic [CNT_W-1:0]   r_i;
    logic [CNT_W-1:0]   r_j;
    logic               r_ok;
    logic               r_cmp_vld;
    logic               r_out_vld;
    logic               r_out_flag;

    logic [CNT_W-1:0]   rows;
    logic [CNT_W-1:0]   cols;
    logic [CNT_W-1:0]   outer_lim;
    logic [CNT_W-1:0]   inner_end;
    logic [CNT_W-1:0]   b_row;
    logic [CNT_W-1:0]   b_col;
    logic               kind_ok;
    logic               never_true;
    logic               no_pairs;
    logic               ld_accept;
    logic               ld_col_last;
    logic               ld_last;
    logic               last_inner;
    logic               last_outer;
    logic               is_diag;
    logic               rd_eq;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [DATA_W-1:0]  rd_data_a;
    logic [DATA_W-1:0]  rd_data_b;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            return CNT_W'(MAX_DIM);
        end else begin
            return CNT_W'(v);
        end
    endfunction

    assign rows    = clamp_dim(r_row_count);
    assign cols    = clamp_dim(r_col_count);
    assign is_diag = (r_test_kind == KIND_DIAG);

    always_comb begin
        case (r_test_kind)
            KIND_VERT: begin
                outer_lim = rows;
                inner_end = cols >> 1;
                kind_ok   = 1'b1;
                b_row     = r_i;
                b_col     = cols - r_j - CNT_W'(1);
            end
            KIND_HORZ: begin
                outer_lim = rows >> 1;
                inner_end = cols;
                kind_ok   = 1'b1;
                b_row     = rows - r_i - CNT_W'(1);
                b_col     = r_j;
            end
            KIND_DIAG: begin
                outer_lim = rows - CNT_W'(1);
                inner_end = cols;
                kind_ok   = (rows == cols);
                b_row     = r_j;
                b_col     = r_i;
            end
            default: begin
                outer_lim = '0;
                inner_end = '0;
                kind_ok   = 1'b0;
                b_row     = r_i;
                b_col     = r_j;
            end
        endcase
    end

    assign never_true  = !kind_ok;
    assign no_pairs    = (outer_lim == '0) || (inner_end == '0);
    assign ld_accept   = i_start && !o_busy;
    assign ld_col_last = (r_ld_col + CNT_W'(1) == cols);
    assign ld_last     = ld_col_last && (r_ld_row + CNT_W'(1) == rows);
    assign last_inner  = (r_j + CNT_W'(1) == inner_end);
    assign last_outer  = (r_i + CNT_W'(1) == outer_lim);
    assign rd_eq       = (rd_data_a == rd_data_b);

    assign wr_addr   = {r_ld_row[DIM_W-1:0], r_ld_col[DIM_W-1:0]};
    assign rd_addr_a = {r_i[DIM_W-1:0], r_j[DIM_W-1:0]};
    assign rd_addr_b = {b_row[DIM_W-1:0], b_col[DIM_W-1:0]};

    msc_store u_store (
        .i_clk       (i_clk),
        .i_wr_en     (ld_accept),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_element_value),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= CFG_W'(1);
            r_col_count <= CFG_W'(1);
            r_test_kind <= KIND_VERT;
            r_ld_row    <= '0;
            r_ld_col    <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ok        <= 1'b1;
            r_cmp_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_out_flag  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            r_cmp_vld <= (r_state == S_WALK);

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data;
                        r_ld_row    <= '0;
                        r_ld_col    <= '0;
                    end
                    REG_COL_COUNT: begin
                        r_col_count <= i_cfg_data;
                        r_ld_row    <= '0;
                        r_ld_col    <= '0;
                    end
                    REG_TEST_KIND: begin
                        r_test_kind <= i_cfg_data[KIND_W-1:0];
                        r_ld_row    <= '0;
                        r_ld_col    <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (ld_accept) begin
                if (ld_last) begin
                    r_ld_row <= '0;
                    r_ld_col <= '0;
                    r_i      <= '0;
                    r_j      <= is_diag ? CNT_W'(1) : '0;
                    r_ok     <= 1'b1;
                    if (never_true) begin
                        r_out_vld  <= 1'b1;
                        r_out_flag <= 1'b0;
                    end else if (no_pairs) begin
                        r_out_vld  <= 1'b1;
                        r_out_flag <= 1'b1;
                    end else begin
                        r_state <= S_WALK;
                    end
                end else if (ld_col_last) begin
                    r_ld_col <= '0;
                    r_ld_row <= r_ld_row + CNT_W'(1);
                end else begin
                    r_ld_col <= r_ld_col + CNT_W'(1);
                end
            end

            case (r_state)
                S_IDLE: begin
                end
                S_WALK: begin
                    if (r_cmp_vld && !rd_eq) begin
                        r_ok <= 1'b0;
                    end
                    if (last_inner) begin
                        if (last_outer) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + CNT_W'(1);
                            r_j <= is_diag ? r_i + CNT_W'(2) : '0;
                        end
                    end else begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_out_vld  <= 1'b1;
                    r_out_flag <= r_ok && (!r_cmp_vld || rd_eq);
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_out_vld;
    assign o_is_symmetric = r_out_flag;

    `MSC_ASSERT(a_drain_gives_result, i_clk, i_rst_n, (r_state == S_DRAIN) |=> o_valid)
    `MSC_NEVER(a_result_while_busy, i_clk, i_rst_n, o_valid && o_busy)
    `MSC_ASSERT(a_compare_follows_walk, i_clk, i_rst_n, r_cmp_vld |-> $past(r_state == S_WALK))
    `MSC_ASSERT(a_drain_has_compare, i_clk, i_rst_n, (r_state == S_DRAIN) |-> r_cmp_vld)

endmodule
